### rtl/core/mdew_pkg.sv
`timescale 1ns / 1ps
package mdew_pkg;

  // Item kinds carried in tuser
  localparam logic [1:0] KIND_ENCODER = 2'd0;
  localparam logic [1:0] KIND_SPEED   = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [7:0]  IDLE_DUTY   = 8'd255;
  localparam logic [6:0]  SPEED_MAX   = 7'd100;
  localparam logic [15:0] LIMIT_RESET = 16'd250;

  // Scale magnitude by 255/100: (mag * 255 * 5243) >> 19 is exact for mag <= 100
  localparam logic [26:0] SCALE_MUL   = 27'd1336965;
  localparam int          SCALE_SHIFT = 19;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  typedef struct packed {
    logic [1:0]        kind;
    logic              phase_a;
    logic              phase_b;
    logic signed [7:0] speed_command;
  } item_t;

  typedef struct packed {
    logic              watchdog_alarm;
    logic signed [31:0] position_count;
    logic [7:0]        pwm_b;
    logic [7:0]        pwm_a;
  } result_t;

endpackage

### rtl/core/mdew_in_reg.sv
`timescale 1ns / 1ps
module mdew_in_reg
  import mdew_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  // Accept a new beat whenever the slot is empty or drains this cycle
  assign in_ready = !item_valid || item_take;

  // Track occupancy of the input slot
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  // Capture the payload on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

### rtl/core/mdew_state.sv
`timescale 1ns / 1ps
module mdew_state
  import mdew_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_take,
  output logic        res_valid,
  output result_t     res,
  input  logic        res_ready
);

  logic               prev_a;
  logic               prev_b;
  logic [31:0]        count_reg;
  logic [15:0]        idle_ticks;
  logic [7:0]         duty_a;
  logic [7:0]         duty_b;
  logic               alarm_flag;
  logic [15:0]        watchdog_limit;

  logic               prev_a_next;
  logic               prev_b_next;
  logic [31:0]        count_next;
  logic [15:0]        idle_next;
  logic [7:0]         duty_a_next;
  logic [7:0]         duty_b_next;
  logic               alarm_next;

  logic               advance;
  logic               spd_neg;
  logic [8:0]         mag_raw;
  logic [6:0]         mag;
  logic [26:0]        scale_prod;
  logic [7:0]         scaled_duty;
  logic [15:0]        idle_inc;

  assign item_take = !res_valid || res_ready;
  assign advance   = item_valid && item_take;

  // Clamp the speed magnitude and scale it to 0..255
  assign spd_neg     = item.speed_command[7];
  assign mag_raw     = spd_neg ? (9'd256 - {1'b0, item.speed_command})
                               : {1'b0, item.speed_command};
  assign mag         = (mag_raw > {2'b00, SPEED_MAX}) ? SPEED_MAX : mag_raw[6:0];
  assign scale_prod  = {20'd0, mag} * SCALE_MUL;
  assign scaled_duty = scale_prod[SCALE_SHIFT +: 8];

  // Saturating watchdog increment
  assign idle_inc = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;

  // Compute the state after this beat
  always_comb begin
    prev_a_next = prev_a;
    prev_b_next = prev_b;
    count_next  = count_reg;
    idle_next   = idle_ticks;
    duty_a_next = duty_a;
    duty_b_next = duty_b;
    alarm_next  = alarm_flag;
    case (item.kind)
      KIND_ENCODER: begin
        if (item.phase_a != prev_a) begin
          prev_a_next = item.phase_a;
          count_next  = (item.phase_a == item.phase_b) ? count_reg + 32'd1
                                                       : count_reg - 32'd1;
        end else if (item.phase_b != prev_b) begin
          prev_b_next = item.phase_b;
          count_next  = (item.phase_a == item.phase_b) ? count_reg - 32'd1
                                                       : count_reg + 32'd1;
        end
      end
      KIND_SPEED: begin
        duty_a_next = IDLE_DUTY;
        duty_b_next = IDLE_DUTY;
        if (item.speed_command != 8'sd0) begin
          if (spd_neg) begin
            duty_b_next = IDLE_DUTY - scaled_duty;
          end else begin
            duty_a_next = IDLE_DUTY - scaled_duty;
          end
        end
        idle_next = 16'd0;
      end
      KIND_TICK: begin
        idle_next = idle_inc;
        if (idle_inc > watchdog_limit) begin
          duty_a_next = IDLE_DUTY;
          duty_b_next = IDLE_DUTY;
          alarm_next  = 1'b1;
        end else begin
          alarm_next  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the watchdog limit written over the config port
  always_ff @(posedge clk) begin
    if (rst) begin
      watchdog_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      watchdog_limit <= cfg_wr_data;
    end
  end

  // Commit the state update when a beat moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a     <= 1'b0;
      prev_b     <= 1'b0;
      count_reg  <= 32'd0;
      idle_ticks <= 16'd0;
      duty_a     <= IDLE_DUTY;
      duty_b     <= IDLE_DUTY;
      alarm_flag <= 1'b0;
    end else if (advance) begin
      prev_a     <= prev_a_next;
      prev_b     <= prev_b_next;
      count_reg  <= count_next;
      idle_ticks <= idle_next;
      duty_a     <= duty_a_next;
      duty_b     <= duty_b_next;
      alarm_flag <= alarm_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res.pwm_a          <= duty_a_next;
      res.pwm_b          <= duty_b_next;
      res.position_count <= count_next;
      res.watchdog_alarm <= alarm_next;
    end
  end

`ifndef SYNTHESIS
  // Never drive both bridge sides at once
  assert property (@(posedge clk) disable iff (rst)
    (duty_a == IDLE_DUTY) || (duty_b == IDLE_DUTY))
    else $error("both bridge sides active");

  // A tick past the limit raises the alarm and stops the motor
  assert property (@(posedge clk) disable iff (rst)
    (advance && item.kind == KIND_TICK && idle_inc > watchdog_limit)
    |=> (alarm_flag && duty_a == IDLE_DUTY && duty_b == IDLE_DUTY))
    else $error("alarm tick left motor running");

  // A speed command clears the watchdog
  assert property (@(posedge clk) disable iff (rst)
    (advance && item.kind == KIND_SPEED) |=> (idle_ticks == 16'd0))
    else $error("watchdog not cleared by speed command");

  // A phase A change steps the count by exactly one
  assert property (@(posedge clk) disable iff (rst)
    (advance && item.kind == KIND_ENCODER && item.phase_a != prev_a)
    |=> (count_reg == $past(count_reg) + 32'd1 || count_reg == $past(count_reg) - 32'd1))
    else $error("encoder step not unit");

  // The result register reflects the committed state
  assert property (@(posedge clk) disable iff (rst)
    advance |=> (res.position_count == count_reg && res.pwm_a == duty_a
                 && res.pwm_b == duty_b && res.watchdog_alarm == alarm_flag))
    else $error("result does not match state");
`endif

endmodule

### rtl/core/motor_driver_encoder_watchdog.sv
`timescale 1ns / 1ps
// Motor driver: quadrature encoder counter, H-bridge PWM setter, command watchdog.
// Input stream (s_axis): tuser carries the kind (encoder sample, speed command,
// tick); tdata carries phase_a, phase_b and the signed speed percent.
// Output stream (m_axis): one beat per input beat, in order, with both PWM
// compare values, the 32-bit wrapping position count and the alarm flag.
// Config: cfg_wr_en with cfg_wr_data writes the watchdog limit in ticks.
// Path: an accepted beat goes from the input register through the update logic
// into the result register. Throughput: one beat per cycle while m_axis_tready
// is high.
// Reset (rst, synchronous): count and phase history cleared, watchdog cleared,
// both PWM compares idle at 255, alarm low, limit back to 250.
// Stall: while m_axis_tready is low the result beat holds; one more input beat
// is taken into the input register, then s_axis_tready drops.
module motor_driver_encoder_watchdog
  import mdew_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [15:0]            cfg_wr_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [0] phase_a, [1] phase_b, [9:2] speed_command, [15:10] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] pwm_a, [15:8] pwm_b, [47:16] position_count, [48] watchdog_alarm,
  // [55:49] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  result_t res;

  // Unpack the input beat
  assign in_item.kind          = s_axis_tuser;
  assign in_item.phase_a       = s_axis_tdata[0];
  assign in_item.phase_b       = s_axis_tdata[1];
  assign in_item.speed_command = s_axis_tdata[9:2];

  mdew_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  mdew_state u_state (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .res_valid   (m_axis_tvalid),
    .res         (res),
    .res_ready   (m_axis_tready)
  );

  // Pack the result beat
  assign m_axis_tdata = {7'd0, res};

endmodule

### dv/motor_status_checker.sv
`timescale 1ns / 1ps
module motor_status_checker
  import mdew_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [15:0]            cfg_wr_data,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // [0] phase_a, [1] phase_b, [9:2] speed_command, [15:10] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]             s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] pwm_a, [15:8] pwm_b, [47:16] position_count, [48] watchdog_alarm
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     mismatches,
  output int                     outstanding
);

  // Shadow copy of the drive state
  logic [15:0] limit_q;
  logic        last_a;
  logic        last_b;
  logic [31:0] count_q;
  logic [15:0] idle_q;
  logic [7:0]  duty_a_q;
  logic [7:0]  duty_b_q;
  logic        alarm_q;

  // Motor status owed for beats already taken in, oldest first
  result_t motor_status_q[$];
  result_t got_status;
  result_t want_status;
  result_t new_status;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // Bridge compare for a speed percent: 255 minus the scaled magnitude
  function automatic logic [7:0] bridge_compare(input logic [7:0] speed);
    logic [8:0]  mag;
    logic [15:0] scaled;
    mag = speed[7] ? (9'd256 - {1'b0, speed}) : {1'b0, speed};
    if (mag > 9'd100) mag = 9'd100;
    scaled = ({7'd0, mag} * 16'd255) / 16'd100;
    return IDLE_DUTY - scaled[7:0];
  endfunction

  // Advance the drive state by one item and return the status it reports
  task automatic advance_drive_state(input logic [1:0] kind, input logic a, input logic b,
                                     input logic [7:0] speed, output result_t status);
    case (kind)
      KIND_ENCODER: begin
        if (a != last_a) begin
          last_a = a;
          count_q = (a == b) ? count_q + 32'd1 : count_q - 32'd1;
        end else if (b != last_b) begin
          last_b = b;
          count_q = (a == b) ? count_q - 32'd1 : count_q + 32'd1;
        end
      end
      KIND_SPEED: begin
        duty_a_q = IDLE_DUTY;
        duty_b_q = IDLE_DUTY;
        if (speed != 8'd0) begin
          if (speed[7]) duty_b_q = bridge_compare(speed);
          else duty_a_q = bridge_compare(speed);
        end
        idle_q = 16'd0;
      end
      KIND_TICK: begin
        if (idle_q != 16'hFFFF) idle_q = idle_q + 16'd1;
        if (idle_q > limit_q) begin
          duty_a_q = IDLE_DUTY;
          duty_b_q = IDLE_DUTY;
          alarm_q = 1'b1;
        end else begin
          alarm_q = 1'b0;
        end
      end
      default: ;
    endcase
    status.pwm_a = duty_a_q;
    status.pwm_b = duty_b_q;
    status.position_count = count_q;
    status.watchdog_alarm = alarm_q;
  endtask

  // Watch both channels and the register port at every rising edge
  always @(posedge clk) begin
    if (rst) begin
      limit_q = LIMIT_RESET;
      last_a = 1'b0;
      last_b = 1'b0;
      count_q = 32'd0;
      idle_q = 16'd0;
      duty_a_q = IDLE_DUTY;
      duty_b_q = IDLE_DUTY;
      alarm_q = 1'b0;
      mismatches = 0;
      motor_status_q.delete();
    end else begin
      if (cfg_wr_en) limit_q = cfg_wr_data;
      // Compare a result beat with the oldest owed status
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = result_t'(m_axis_tdata[48:0]);
        if (motor_status_q.size() == 0) begin
          report_mismatch("result beat with nothing owed", got_status.position_count, 32'd0);
        end else begin
          want_status = motor_status_q.pop_front();
          if (got_status.pwm_a !== want_status.pwm_a)
            report_mismatch("pwm_a", {24'd0, got_status.pwm_a}, {24'd0, want_status.pwm_a});
          if (got_status.pwm_b !== want_status.pwm_b)
            report_mismatch("pwm_b", {24'd0, got_status.pwm_b}, {24'd0, want_status.pwm_b});
          if (got_status.position_count !== want_status.position_count)
            report_mismatch("position_count", got_status.position_count,
                            want_status.position_count);
          if (got_status.watchdog_alarm !== want_status.watchdog_alarm)
            report_mismatch("watchdog_alarm", {31'd0, got_status.watchdog_alarm},
                            {31'd0, want_status.watchdog_alarm});
        end
      end
      // Predict the status for an input beat
      if (s_axis_tvalid && s_axis_tready) begin
        advance_drive_state(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[1],
                            s_axis_tdata[9:2], new_status);
        motor_status_q.push_back(new_status);
      end
    end
    outstanding = motor_status_q.size();
  end

endmodule

### dv/motor_driver_encoder_watchdog_test.sv
`timescale 1ns / 1ps
module motor_driver_encoder_watchdog_test;
  import mdew_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 200;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [15:0]            cfg_wr_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  int idle_cycles;
  int stall_left;
  bit hold_req = 1'b0;
  bit no_stall = 1'b0;
  bit burst = 1'b0;
  int enc_pos = 0;
  bit enc_fwd = 1'b1;

  motor_driver_encoder_watchdog i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  motor_status_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap length in cycles: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat, with a random gap ahead of it, and hold until taken
  task automatic send_item(input logic [1:0] kind, input logic a, input logic b,
                           input logic [7:0] speed);
    int gap;
    gap = (burst || $urandom_range(0, 99) < 55) ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {6'd0, speed, b, a};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Random item: mostly clean quadrature steps, speed commands and ticks
  task automatic send_random_item(input int speed_pct);
    int r;
    logic [1:0] kind;
    logic [1:0] ab;
    logic [7:0] speed;
    r = $urandom_range(0, 99);
    ab = 2'($urandom_range(0, 3));
    speed = 8'($urandom_range(0, 255));
    if (r < 4) kind = KIND_UNUSED;
    else if (r < 4 + speed_pct) kind = KIND_SPEED;
    else if (r < 34 + speed_pct) kind = KIND_TICK;
    else kind = KIND_ENCODER;
    if (kind == KIND_SPEED && $urandom_range(0, 99) < 30) begin
      case ($urandom_range(0, 9))
        0: speed = 8'd0;
        1: speed = 8'd1;
        2: speed = 8'hFF;
        3: speed = 8'd99;
        4: speed = 8'd100;
        5: speed = 8'd101;
        6: speed = 8'd127;
        7: speed = 8'h80;
        8: speed = 8'h9C;
        default: speed = 8'h9B;
      endcase
    end
    if (kind == KIND_ENCODER) begin
      if ($urandom_range(0, 99) < 10) begin
        // Noise: arbitrary levels, then resync the walk to them
        case (ab)
          2'b00: enc_pos = 0;
          2'b01: enc_pos = 1;
          2'b11: enc_pos = 2;
          default: enc_pos = 3;
        endcase
      end else begin
        if ($urandom_range(0, 99) < 5) enc_fwd = !enc_fwd;
        enc_pos = enc_fwd ? (enc_pos + 1) % 4 : (enc_pos + 3) % 4;
        case (enc_pos)
          0: ab = 2'b00;
          1: ab = 2'b01;
          2: ab = 2'b11;
          default: ab = 2'b10;
        endcase
      end
    end
    send_item(kind, ab[0], ab[1], speed);
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_watchdog_limit(input logic [15:0] limit);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: random ready with stalls, one long hold-off on request
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (no_stall || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = gap_len() - 1;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Stimulus
  initial begin
    int ph;
    int n;
    int speed_pct;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: unused kind, quadrature steps, both phases at once
    send_item(KIND_UNUSED, 1'b1, 1'b1, 8'hFF);
    send_item(KIND_ENCODER, 1'b0, 1'b1, 8'h00);
    send_item(KIND_ENCODER, 1'b1, 1'b1, 8'hFF);
    send_item(KIND_ENCODER, 1'b1, 1'b0, 8'h00);
    send_item(KIND_ENCODER, 1'b0, 1'b1, 8'h00);
    send_item(KIND_ENCODER, 1'b0, 1'b1, 8'h00);
    send_item(KIND_ENCODER, 1'b1, 1'b1, 8'h00);
    // Speed extremes, clamp above 100 and the most negative byte
    send_item(KIND_SPEED, 1'b1, 1'b0, 8'd127);
    send_item(KIND_SPEED, 1'b0, 1'b1, 8'h80);
    send_item(KIND_SPEED, 1'b0, 1'b0, 8'd100);
    send_item(KIND_SPEED, 1'b0, 1'b0, 8'd101);
    send_item(KIND_SPEED, 1'b0, 1'b0, 8'h9C);
    send_item(KIND_SPEED, 1'b0, 1'b0, 8'hFF);
    send_item(KIND_SPEED, 1'b0, 1'b0, 8'd1);
    send_item(KIND_SPEED, 1'b0, 1'b0, 8'd99);
    send_item(KIND_TICK, 1'b1, 1'b1, 8'd50);
    send_item(KIND_SPEED, 1'b0, 1'b0, 8'd0);
    send_item(KIND_TICK, 1'b0, 1'b0, 8'h00);
    // Zero limit: first tick stops the motor, speed keeps the alarm
    set_watchdog_limit(16'd0);
    send_item(KIND_SPEED, 1'b0, 1'b0, 8'd60);
    send_item(KIND_TICK, 1'b0, 1'b0, 8'h00);
    send_item(KIND_SPEED, 1'b0, 1'b0, 8'hC0);
    send_item(KIND_UNUSED, 1'b0, 1'b0, 8'h00);
    send_item(KIND_TICK, 1'b0, 1'b0, 8'h00);
    // Top limit: never raised
    set_watchdog_limit(16'hFFFF);
    send_item(KIND_TICK, 1'b0, 1'b0, 8'h00);
    send_item(KIND_TICK, 1'b0, 1'b0, 8'h00);
    set_watchdog_limit(LIMIT_RESET);

    // Random phases over several limits
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        1: set_watchdog_limit(16'd3);
        2: set_watchdog_limit(16'd0);
        3: set_watchdog_limit(16'hFFFF);
        4: set_watchdog_limit(16'($urandom_range(0, 65535)));
        5: set_watchdog_limit(16'd1);
        6: set_watchdog_limit(16'd12);
        default: ;
      endcase
      speed_pct = (ph % 2 == 0) ? 20 : 6;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Odd phases open with a stretch without idling
        burst = (ph % 2 == 1) && (n < 50);
        no_stall = burst;
        if (ph == 2 && n == 60) begin
          // Long receiver hold-off while the sender keeps offering
          hold_req = 1'b1;
          burst = 1'b1;
          repeat (30) send_random_item(speed_pct);
          burst = 1'b0;
        end
        if (ph == 4 && n == 100) wait_for_results();
        send_random_item(speed_pct);
      end
    end
    burst = 1'b0;
    no_stall = 1'b0;

    // Closing items under a short limit
    set_watchdog_limit(16'd1);
    send_item(KIND_TICK, 1'b1, 1'b0, 8'h00);
    send_item(KIND_SPEED, 1'b0, 1'b0, 8'hCE);
    send_item(KIND_TICK, 1'b0, 1'b0, 8'h00);
    send_item(KIND_UNUSED, 1'b0, 1'b1, 8'h00);

    wait_for_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
